// ===== rtl/pid_timed_clamped_core_assert.svh =====
// Assertion macros for the PID core.
`ifndef PID_TIMED_CLAMPED_CORE_ASSERT_SVH
`define PID_TIMED_CLAMPED_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PTC_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define PTC_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PTC_ASSERT_IMPL(label, a, c)
`define PTC_ASSERT_NEXT(label, a, c)
`endif
`endif

// ===== rtl/ptc_pkg.sv =====
package ptc_pkg;
  localparam int DW = 32;
  localparam int FB = 16;
  localparam int TW = 32;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_BOUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_BOUND = 3'd4;

  typedef struct packed {
    logic [DW-1:0] timestamp;
    logic signed [DW-1:0] measured_value;
    logic signed [DW-1:0] target_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] drive;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_PTERM, OP_INC1, OP_INC2, OP_INTEG,
    OP_DIV_START, OP_DIV_STEP, OP_DTERM, OP_SUM, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } ptc_cmd_t;

  typedef struct packed {
    logic div_done;
  } ptc_stat_t;

  // saturate 66-bit signed value to DW bits
  function automatic logic signed [DW-1:0] sat66(input logic signed [65:0] v);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    mx = 66'sd2147483647;
    mn = -66'sd2147483648;
    if (v > mx) return 32'sh7fffffff;
    if (v < mn) return 32'sh80000000;
    return v[DW-1:0];
  endfunction
endpackage

// ===== rtl/ptc_if.sv =====
interface ptc_in_if;
  import ptc_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ptc_out_if;
  import ptc_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/ptc_datapath.sv =====
module ptc_datapath (
  input  logic clk,
  input  ptc_pkg::ptc_cmd_t cmd,
  output ptc_pkg::ptc_stat_t stat,
  input  logic rst,
  input  ptc_pkg::in_item_t item,
  input  logic signed [31:0] prop_gain,
  input  logic signed [31:0] integ_gain,
  input  logic signed [31:0] deriv_gain,
  input  logic [30:0] integ_bound,
  input  logic [30:0] drive_bound,
  output logic signed [31:0] drive
);
  import ptc_pkg::*;

  logic signed [DW-1:0] err, integ_accum, prev_error, pterm, inc, dterm, res;
  logic [TW-1:0] prev_time, elapsed, now;
  // shared multiplier
  logic signed [DW-1:0] ma, mb;
  logic signed [63:0] prod;
  logic [5:0] shamt;
  logic signed [DW-1:0] msat;
  // divider
  logic [DW-1:0] dq, dr, dden;
  logic [5:0] dcnt;
  logic dneg;
  logic [DW:0] rtrial;
  logic signed [65:0] s1, s2;
  // integral sum, error difference and the two clamp bounds
  logic signed [65:0] isum, dsum;
  logic signed [DW-1:0] dsat;
  logic signed [DW:0] ibnd, obnd;

  always_comb begin
    ma = err;
    mb = prop_gain;
    shamt = 6'(FB);
    case (cmd.op)
      OP_PTERM: begin ma = err; mb = prop_gain; shamt = 6'(FB); end
      OP_INC1: begin ma = err; mb = $signed(elapsed); shamt = 6'd0; end
      OP_INC2: begin ma = inc; mb = integ_gain; shamt = 6'(FB); end
      OP_DTERM: begin
        ma = dneg ? -$signed(dq) : $signed(dq); mb = deriv_gain; shamt = 6'(FB);
      end
      default: ;
    endcase
    // elapsed as unsigned: extend so sign is right
    if (cmd.op == OP_INC1) prod = $signed({1'b0, elapsed}) * 64'(ma);
    else prod = 64'(ma) * 64'(mb);
    msat = sat66(66'(prod >>> shamt));
    rtrial = {dr, dden[DW-1]} - {1'b0, elapsed};
    s1 = 66'(pterm) + 66'(integ_accum);
    s2 = 66'(sat66(s1)) + 66'(dterm);
    isum = 66'(integ_accum) + 66'(inc);
    dsum = 66'(err) - 66'(prev_error);
    dsat = sat66(dsum);
    ibnd = {2'b0, integ_bound};
    obnd = {2'b0, drive_bound};
  end

  assign stat.div_done = (dcnt == 6'd0);
  assign now = item.timestamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_accum <= '0;
      prev_error <= '0;
      prev_time <= '0;
      dcnt <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          err <= sat66(66'(item.measured_value) - 66'(item.target_value));
          elapsed <= now - prev_time;
          prev_time <= now;
        end
        OP_PTERM: pterm <= msat;
        OP_INC1: inc <= msat;
        OP_INC2: inc <= msat;
        OP_INTEG: begin
          if (66'(sat66(isum)) > 66'(ibnd)) integ_accum <= ibnd[DW-1:0];
          else if (66'(sat66(isum)) < -66'(ibnd)) integ_accum <= -ibnd[DW-1:0];
          else integ_accum <= sat66(isum);
        end
        OP_DIV_START: begin
          dden <= dsat < 0 ? -dsat : dsat;
          dneg <= dsat < 0;
          dr <= '0;
          dq <= '0;
          dcnt <= (elapsed == '0) ? 6'd0 : 6'(DW);
        end
        OP_DIV_STEP: if (dcnt != 0) begin
          dcnt <= dcnt - 6'd1;
          dden <= dden << 1;
          if (!rtrial[DW]) begin
            dr <= rtrial[DW-1:0];
            dq <= {dq[DW-2:0], 1'b1};
          end else begin
            dr <= {dr[DW-2:0], dden[DW-1]};
            dq <= {dq[DW-2:0], 1'b0};
          end
        end
        OP_DTERM: dterm <= (elapsed == '0) ? '0 : msat;
        OP_SUM: begin
          if (66'(sat66(s2)) > 66'(obnd)) res <= obnd[DW-1:0];
          else if (66'(sat66(s2)) < -66'(obnd)) res <= -obnd[DW-1:0];
          else res <= sat66(s2);
        end
        OP_FINISH: begin
          prev_error <= err;
        end
        default: ;
      endcase
    end
  end

  assign drive = res;
endmodule

// ===== rtl/ptc_ctrl.sv =====
module ptc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  ptc_pkg::ptc_stat_t stat,
  output ptc_pkg::ptc_cmd_t cmd
);
  import ptc_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_PT, S_I1, S_I2, S_IN, S_DS, S_DV, S_DT, S_SUM, S_OUT
  } state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_IDLE: cmd.op = in_valid ? OP_LOAD : OP_IDLE;
      S_PT: cmd.op = OP_PTERM;
      S_I1: cmd.op = OP_INC1;
      S_I2: cmd.op = OP_INC2;
      S_IN: cmd.op = OP_INTEG;
      S_DS: cmd.op = OP_DIV_START;
      S_DV: cmd.op = OP_DIV_STEP;
      S_DT: cmd.op = OP_DTERM;
      S_SUM: cmd.op = OP_SUM;
      S_OUT: cmd.op = (out_ready) ? OP_FINISH : OP_IDLE;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_PT;
        S_PT: state <= S_I1;
        S_I1: state <= S_I2;
        S_I2: state <= S_IN;
        S_IN: state <= S_DS;
        S_DS: state <= S_DV;
        S_DV: if (stat.div_done) state <= S_DT;
        S_DT: state <= S_SUM;
        S_SUM: begin state <= S_OUT; out_valid <= 1'b1; end
        S_OUT: if (out_ready) begin state <= S_IDLE; out_valid <= 1'b0; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/pid_timed_clamped_core.sv =====
// PID controller core with integral anti-windup and output clamping.
// Input channel in: timestamp, measured_value, target_value (Q16.16).
// Output channel out: drive (Q16.16), one item per input item.
// Config port: cfg_we, cfg_idx, cfg_data; registers 0..4 are prop_gain,
// integ_gain, deriv_gain, integ_bound, drive_bound. Write only while idle.
// The 32-step restoring divider for the derivative quotient dominates the
// latency from input accept to output valid, plus a shared 32x32 multiplier
// used for four products. When no time has elapsed the divider is skipped.
// One item in flight: in.ready is high only while the core is idle, so a new
// item is accepted only after the previous output has been taken.
// Reset (rst, synchronous) clears gains, bounds, integral, last error and
// last timestamp. A stalled receiver holds drive steady and blocks input.
`include "pid_timed_clamped_core_assert.svh"
module pid_timed_clamped_core #(
  parameter int CFG_W = 32
) (
  input logic clk,
  input logic rst,
  ptc_in_if.sink in,
  ptc_out_if.source out,
  input logic cfg_we,
  input logic [ptc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input logic [CFG_W-1:0] cfg_data
);
  import ptc_pkg::*;

  logic signed [31:0] prop_gain, integ_gain, deriv_gain;
  logic [30:0] integ_bound, drive_bound;
  ptc_cmd_t cmd;
  ptc_stat_t stat;

  // hold config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
      integ_bound <= '0;
      drive_bound <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PROP_GAIN: prop_gain <= cfg_data[31:0];
        REG_INTEG_GAIN: integ_gain <= cfg_data[31:0];
        REG_DERIV_GAIN: deriv_gain <= cfg_data[31:0];
        REG_INTEG_BOUND: integ_bound <= cfg_data[30:0];
        REG_DRIVE_BOUND: drive_bound <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  ptc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .stat(stat), .cmd(cmd)
  );

  ptc_datapath u_dp (
    .clk(clk), .cmd(cmd), .stat(stat), .rst(rst), .item(in.data),
    .prop_gain(prop_gain), .integ_gain(integ_gain), .deriv_gain(deriv_gain),
    .integ_bound(integ_bound), .drive_bound(drive_bound),
    .drive(out.data.drive)
  );

  `PTC_ASSERT_IMPL(a_no_in_busy, out.valid, !in.ready)
  `PTC_ASSERT_NEXT(a_hold_drive, out.valid && !out.ready, $stable(out.data.drive))
  `PTC_ASSERT_NEXT(a_accept_busy, in.valid && in.ready, !in.ready)
endmodule
